[rtl/ttn_pkg.sv]
// Package for the triangle tangent and normal unit: payload types, widths and codes.
package ttn_pkg;

  // Widths of the fixed-point values along the datapath.
  localparam int COORD_W   = 16;  // input coordinate, Q4.12
  localparam int DIFF_W    = COORD_W + 1;  // edge and UV difference
  localparam int PROD_W    = 2 * DIFF_W;   // one product of two differences
  localparam int WIDE_W    = PROD_W + 1;   // difference of two products
  localparam int NORM_W    = 31;  // magnitude with its top bit placed at bit 30
  localparam int SUM_W     = 64;  // sum of three squares
  localparam int SQ_W      = 2 * NORM_W;
  localparam int ROOT_ITERS = SUM_W / 2;
  localparam int LEN_W     = 32;  // vector length
  localparam int UNIT_FRAC = 14;  // fraction bits of a unit component
  localparam int QUO_W     = UNIT_FRAC + 1;
  localparam int NUM_W     = NORM_W + UNIT_FRAC + 1;
  localparam int OUT_W     = 16;
  localparam int CNT_W     = 5;
  localparam int BIT_W     = 4;   // index of one quotient bit
  localparam int SHIFT_W   = 6;   // shift amount of the root's trial bit

  // Sequencer counts.
  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(7);
  localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(3);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_ITERS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUO_W - 1);

  // Corner position within a triangle.
  localparam logic [1:0] CORNER_FIRST  = 2'd0;
  localparam logic [1:0] CORNER_SECOND = 2'd1;
  localparam logic [1:0] CORNER_LAST   = 2'd2;

  // Product pair steps: determinant, tangent terms, cross product terms.
  localparam logic [2:0] STEP_DET = 3'd0;
  localparam logic [2:0] STEP_T0  = 3'd1;
  localparam logic [2:0] STEP_T1  = 3'd2;
  localparam logic [2:0] STEP_T2  = 3'd3;
  localparam logic [2:0] STEP_N0  = 3'd4;
  localparam logic [2:0] STEP_N1  = 3'd5;
  localparam logic [2:0] STEP_N2  = 3'd6;

  // Vector under normalization.
  localparam logic VEC_TANGENT = 1'b0;
  localparam logic VEC_NORMAL  = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] tex_u;
    logic signed [COORD_W-1:0] tex_v;
  } ttn_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] tangent_x;
    logic signed [OUT_W-1:0] tangent_y;
    logic signed [OUT_W-1:0] tangent_z;
    logic signed [OUT_W-1:0] normal_x;
    logic signed [OUT_W-1:0] normal_y;
    logic signed [OUT_W-1:0] normal_z;
    logic                    uv_degenerate;
    logic                    area_degenerate;
  } ttn_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_NLOAD,
    ST_NSHIFT,
    ST_SQ,
    ST_SQRT,
    ST_DINIT,
    ST_DIV,
    ST_STORE,
    ST_DONE
  } ttn_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             cap0;
    logic             cap1;
    logic             load_diff;
    logic             mul_issue;
    logic             sel;
    logic             nload;
    logic             nshift;
    logic             sq_issue;
    logic             sq_first;
    logic             sq_acc;
    logic             sqrt_step;
    logic             div_init;
    logic             div_step;
    logic             store;
    logic             store_zero;
    logic             out_load;
    logic [CNT_W-1:0] cnt;
  } ttn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic det_zero;
    logic mx_zero;
    logic mx_ok;
  } ttn_status_t;

  // Sign-extended difference of two coordinates.
  function automatic logic signed [DIFF_W-1:0] sub_ext(logic signed [COORD_W-1:0] a,
                                                       logic signed [COORD_W-1:0] b);
    sub_ext = {a[COORD_W-1], a} - {b[COORD_W-1], b};
  endfunction

endpackage

[rtl/ttn_datapath.sv]
// Datapath: held corners, product pairs, normalization, square root and division.
module ttn_datapath import ttn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ttn_in_t     in_data,
  input  ttn_cmd_t    cmd,
  output ttn_status_t status,
  output ttn_out_t    out_data
);

  ttn_in_t corner0_r, corner1_r;
  logic signed [DIFF_W-1:0] e1_r [3];
  logic signed [DIFF_W-1:0] e2_r [3];
  logic signed [DIFF_W-1:0] d1u_r, d1v_r, d2u_r, d2v_r;

  logic signed [DIFF_W-1:0] ma0, mb0, ma1, mb1;
  logic signed [PROD_W-1:0] p0_r, p1_r;
  logic                     wb_v_r;
  logic [2:0]               wb_step_r;
  logic signed [WIDE_W-1:0] wb_val;
  logic                     wb_swap;
  logic signed [WIDE_W-1:0] det_r;
  logic signed [WIDE_W-1:0] t_r [3];
  logic signed [WIDE_W-1:0] n_r [3];

  logic [WIDE_W-1:0] nm_r [3];
  logic [WIDE_W-1:0] nmx_r;
  logic [2:0]        nsgn_r;
  logic [WIDE_W-1:0] ld_mag [3];
  logic [WIDE_W-1:0] ld_mx;
  logic signed [WIDE_W-1:0] ld_src [3];

  logic [NORM_W-1:0] sq_in;
  logic [SQ_W-1:0]   sq_r;
  logic [SUM_W-1:0]  sum_r, root_r, trial, root_bit;
  logic [LEN_W-1:0]  len;

  logic [NUM_W-1:0]  num_r [3];
  logic [QUO_W-1:0]  q_r [3];
  logic [NUM_W-1:0]  dsh;
  logic [BIT_W-1:0]  qbit;

  logic signed [OUT_W-1:0] tan_r [3];
  logic signed [OUT_W-1:0] nor_r [3];
  logic                    uv_r, area_r;
  ttn_out_t                out_r;

  // Hold the first two corners and form the differences on the third.
  always_ff @(posedge clk) begin
    if (cmd.cap0) begin
      corner0_r <= in_data;
    end
    if (cmd.cap1) begin
      corner1_r <= in_data;
    end
    if (cmd.load_diff) begin
      e1_r[0] <= sub_ext(corner1_r.pos_x, corner0_r.pos_x);
      e1_r[1] <= sub_ext(corner1_r.pos_y, corner0_r.pos_y);
      e1_r[2] <= sub_ext(corner1_r.pos_z, corner0_r.pos_z);
      e2_r[0] <= sub_ext(in_data.pos_x, corner0_r.pos_x);
      e2_r[1] <= sub_ext(in_data.pos_y, corner0_r.pos_y);
      e2_r[2] <= sub_ext(in_data.pos_z, corner0_r.pos_z);
      d1u_r   <= sub_ext(corner1_r.tex_u, corner0_r.tex_u);
      d1v_r   <= sub_ext(corner1_r.tex_v, corner0_r.tex_v);
      d2u_r   <= sub_ext(in_data.tex_u, corner0_r.tex_u);
      d2v_r   <= sub_ext(in_data.tex_v, corner0_r.tex_v);
    end
  end

  // Operand selection for the two multipliers.
  always_comb begin
    ma0 = '0;
    mb0 = '0;
    ma1 = '0;
    mb1 = '0;
    unique case (cmd.cnt[2:0])
      STEP_DET: begin
        ma0 = d1u_r; mb0 = d2v_r; ma1 = d2u_r; mb1 = d1v_r;
      end
      STEP_T0: begin
        ma0 = d2v_r; mb0 = e1_r[0]; ma1 = d1v_r; mb1 = e2_r[0];
      end
      STEP_T1: begin
        ma0 = d2v_r; mb0 = e1_r[1]; ma1 = d1v_r; mb1 = e2_r[1];
      end
      STEP_T2: begin
        ma0 = d2v_r; mb0 = e1_r[2]; ma1 = d1v_r; mb1 = e2_r[2];
      end
      STEP_N0: begin
        ma0 = e1_r[1]; mb0 = e2_r[2]; ma1 = e1_r[2]; mb1 = e2_r[1];
      end
      STEP_N1: begin
        ma0 = e1_r[2]; mb0 = e2_r[0]; ma1 = e1_r[0]; mb1 = e2_r[2];
      end
      STEP_N2: begin
        ma0 = e1_r[0]; mb0 = e2_r[1]; ma1 = e1_r[1]; mb1 = e2_r[0];
      end
      default: begin
      end
    endcase
  end

  // Product registers; the difference is written back in the following cycle.
  always_ff @(posedge clk) begin
    if (cmd.mul_issue) begin
      p0_r <= ma0 * mb0;
      p1_r <= ma1 * mb1;
    end
    wb_step_r <= cmd.cnt[2:0];
    if (!rst_n) begin
      wb_v_r <= 1'b0;
    end else begin
      wb_v_r <= cmd.mul_issue;
    end
  end

  // A negative determinant flips the tangent by reversing the subtraction.
  always_comb begin
    wb_swap = det_r[WIDE_W-1] &&
              (wb_step_r == STEP_T0 || wb_step_r == STEP_T1 || wb_step_r == STEP_T2);
    if (wb_swap) begin
      wb_val = {p1_r[PROD_W-1], p1_r} - {p0_r[PROD_W-1], p0_r};
    end else begin
      wb_val = {p0_r[PROD_W-1], p0_r} - {p1_r[PROD_W-1], p1_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wb_v_r) begin
      case (wb_step_r)
        STEP_DET: det_r  <= wb_val;
        STEP_T0:  t_r[0] <= wb_val;
        STEP_T1:  t_r[1] <= wb_val;
        STEP_T2:  t_r[2] <= wb_val;
        STEP_N0:  n_r[0] <= wb_val;
        STEP_N1:  n_r[1] <= wb_val;
        STEP_N2:  n_r[2] <= wb_val;
        default: begin
        end
      endcase
    end
  end

  // Magnitudes and their maximum for the vector being normalized.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ld_src[i] = (cmd.sel == VEC_NORMAL) ? n_r[i] : t_r[i];
      ld_mag[i] = ld_src[i][WIDE_W-1] ? WIDE_W'(-ld_src[i]) : WIDE_W'(ld_src[i]);
    end
    ld_mx = ld_mag[0];
    if (ld_mag[1] > ld_mx) begin
      ld_mx = ld_mag[1];
    end
    if (ld_mag[2] > ld_mx) begin
      ld_mx = ld_mag[2];
    end
  end

  assign status.det_zero = (det_r == '0);
  assign status.mx_zero  = (nmx_r == '0);
  assign status.mx_ok    = (nmx_r[WIDE_W-1:NORM_W] == '0) && nmx_r[NORM_W-1];

  // One normalizing step: right by one while too wide, else left by 8, 4, 2 or 1.
  function automatic logic [WIDE_W-1:0] norm_step(logic [WIDE_W-1:0] x,
                                                  logic [WIDE_W-1:0] mx);
    if (mx[WIDE_W-1:NORM_W] != '0) begin
      norm_step = x >> 1;
    end else if (mx[NORM_W-1:NORM_W-8] == '0) begin
      norm_step = x << 8;
    end else if (mx[NORM_W-1:NORM_W-4] == '0) begin
      norm_step = x << 4;
    end else if (mx[NORM_W-1:NORM_W-2] == '0) begin
      norm_step = x << 2;
    end else begin
      norm_step = x << 1;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.nload) begin
      for (int i = 0; i < 3; i++) begin
        nm_r[i]   <= ld_mag[i];
        nsgn_r[i] <= ld_src[i][WIDE_W-1];
      end
      nmx_r <= ld_mx;
    end else if (cmd.nshift) begin
      for (int i = 0; i < 3; i++) begin
        nm_r[i] <= norm_step(nm_r[i], nmx_r);
      end
      nmx_r <= norm_step(nmx_r, nmx_r);
    end
  end

  // Squares one component a cycle into the sum, which the root then consumes.
  always_comb begin
    case (cmd.cnt[1:0])
      2'd0:    sq_in = nm_r[0][NORM_W-1:0];
      2'd1:    sq_in = nm_r[1][NORM_W-1:0];
      2'd2:    sq_in = nm_r[2][NORM_W-1:0];
      default: sq_in = '0;
    endcase
    root_bit = SUM_W'(1) << {~cmd.cnt, 1'b0};
    trial    = root_r + root_bit;
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_issue) begin
      sq_r <= sq_in * sq_in;
    end
    if (cmd.sq_first) begin
      sum_r  <= '0;
      root_r <= '0;
    end else if (cmd.sq_acc) begin
      sum_r <= sum_r + SUM_W'(sq_r);
    end else if (cmd.sqrt_step) begin
      if (sum_r >= trial) begin
        sum_r  <= sum_r - trial;
        root_r <= (root_r >> 1) + root_bit;
      end else begin
        root_r <= root_r >> 1;
      end
    end
  end

  // Rounded quotients, one bit a cycle, three components side by side.
  assign len  = root_r[LEN_W-1:0];
  assign qbit = BIT_W'(DIV_LAST - cmd.cnt);
  assign dsh  = NUM_W'(len) << qbit;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (cmd.div_init) begin
        num_r[i] <= NUM_W'({nm_r[i][NORM_W-1:0], UNIT_FRAC'(0)}) + NUM_W'(len[LEN_W-1:1]);
        q_r[i]   <= '0;
      end else if (cmd.div_step) begin
        if (num_r[i] >= dsh) begin
          num_r[i]     <= num_r[i] - dsh;
          q_r[i][qbit] <= 1'b1;
        end
      end
    end
  end

  // Result registers for the triangle in work.
  always_ff @(posedge clk) begin
    if (cmd.load_diff) begin
      for (int i = 0; i < 3; i++) begin
        tan_r[i] <= '0;
        nor_r[i] <= '0;
      end
      uv_r   <= 1'b0;
      area_r <= 1'b0;
    end else if (cmd.store) begin
      if (cmd.store_zero) begin
        if (cmd.sel == VEC_NORMAL) begin
          area_r <= 1'b1;
        end else begin
          uv_r <= 1'b1;
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          if (cmd.sel == VEC_NORMAL) begin
            nor_r[i] <= nsgn_r[i] ? -OUT_W'({1'b0, q_r[i]}) : OUT_W'({1'b0, q_r[i]});
          end else begin
            tan_r[i] <= nsgn_r[i] ? -OUT_W'({1'b0, q_r[i]}) : OUT_W'({1'b0, q_r[i]});
          end
        end
      end
    end
  end

  // Output register holds the beat until the receiver takes it.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.tangent_x       <= tan_r[0];
      out_r.tangent_y       <= tan_r[1];
      out_r.tangent_z       <= tan_r[2];
      out_r.normal_x        <= nor_r[0];
      out_r.normal_y        <= nor_r[1];
      out_r.normal_z        <= nor_r[2];
      out_r.uv_degenerate   <= uv_r;
      out_r.area_degenerate <= area_r;
    end
  end

  assign out_data = out_r;

endmodule

[rtl/ttn_ctrl.sv]
// Controller: corner counting, configuration register and the step sequencer.
module ttn_ctrl import ttn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  ttn_status_t status,
  output ttn_cmd_t    cmd
);

  ttn_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             sel_r, sel_nxt;
  logic [1:0]       corner_r, corner_nxt;
  logic             ne_r, ne_tri_r, ne_tri_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_acc;
  ttn_state_t       after_state;
  logic             after_sel;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // Where to go once a vector is finished.
  always_comb begin
    if (sel_r == VEC_TANGENT && ne_tri_r) begin
      after_state = ST_NLOAD;
      after_sel   = VEC_NORMAL;
    end else begin
      after_state = ST_DONE;
      after_sel   = sel_r;
    end
  end

  // Next state.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    sel_nxt    = sel_r;
    corner_nxt = corner_r;
    ne_tri_nxt = ne_tri_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (corner_r == CORNER_LAST) begin
            corner_nxt = CORNER_FIRST;
            ne_tri_nxt = ne_r;
            state_nxt  = ST_MUL;
            cnt_nxt    = '0;
          end else begin
            corner_nxt = corner_r + 2'd1;
          end
        end
      end
      ST_MUL: begin
        if (cnt_r == MUL_LAST) begin
          state_nxt = ST_NLOAD;
          sel_nxt   = VEC_TANGENT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_NLOAD: begin
        if (sel_r == VEC_TANGENT && status.det_zero) begin
          state_nxt = after_state;
          sel_nxt   = after_sel;
        end else begin
          state_nxt = ST_NSHIFT;
        end
      end
      ST_NSHIFT: begin
        if (status.mx_zero) begin
          state_nxt = after_state;
          sel_nxt   = after_sel;
        end else if (status.mx_ok) begin
          state_nxt = ST_SQ;
          cnt_nxt   = '0;
        end
      end
      ST_SQ: begin
        if (cnt_r == SQ_LAST) begin
          state_nxt = ST_SQRT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SQRT: begin
        if (cnt_r == SQRT_LAST) begin
          state_nxt = ST_DINIT;
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_DINIT: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_STORE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_STORE: begin
        state_nxt = after_state;
        sel_nxt   = after_sel;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd     = '0;
    cmd.cnt = cnt_r;
    cmd.sel = sel_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.cap0      = in_acc && (corner_r == CORNER_FIRST);
        cmd.cap1      = in_acc && (corner_r == CORNER_SECOND);
        cmd.load_diff = in_acc && (corner_r == CORNER_LAST);
      end
      ST_MUL: begin
        cmd.mul_issue = (cnt_r != MUL_LAST);
      end
      ST_NLOAD: begin
        if (sel_r == VEC_TANGENT && status.det_zero) begin
          cmd.store      = 1'b1;
          cmd.store_zero = 1'b1;
        end else begin
          cmd.nload = 1'b1;
        end
      end
      ST_NSHIFT: begin
        if (status.mx_zero) begin
          cmd.store      = 1'b1;
          cmd.store_zero = 1'b1;
        end else if (!status.mx_ok) begin
          cmd.nshift = 1'b1;
        end
      end
      ST_SQ: begin
        cmd.sq_issue = (cnt_r != SQ_LAST);
        cmd.sq_first = (cnt_r == '0);
        cmd.sq_acc   = (cnt_r != '0);
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_STORE: begin
        cmd.store = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = !out_valid_r || !out_stall;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      sel_r       <= VEC_TANGENT;
      corner_r    <= CORNER_FIRST;
      ne_r        <= 1'b1;
      ne_tri_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      corner_r    <= corner_nxt;
      ne_tri_r    <= ne_tri_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        ne_r <= cfg_wr_data;
      end
    end
  end

  // A new result never overwrites a beat that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a waiting beat");

  // A taken beat with nothing new behind it leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !cmd.out_load) |=> !out_valid_r)
    else $error("output stayed valid after the beat was taken");

  // The corner count never reaches a fourth corner.
  a_corner: assert property (@(posedge clk) disable iff (!rst_n)
    corner_r != 2'd3)
    else $error("corner count out of range");

  // The normal is only worked on when it was enabled for this triangle.
  a_normal_en: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && state_r != ST_MUL && sel_r == VEC_NORMAL) |-> ne_tri_r)
    else $error("normal computed while disabled");

endmodule

[rtl/triangle_tangent_normal.sv]
// Top level of the triangle tangent and normal unit.
//
// Corners arrive on the in_ channel (in_valid, in_stall, in_data), three beats
// per triangle. The first two beats are held; the third starts the work and
// produces one beat on the out_ channel (out_valid, out_stall, out_data) with
// the unit tangent, the unit face normal (zero when normals are off) and two
// degenerate flags. A beat moves when valid is high and stall is low.
// cfg_wr_en with cfg_wr_data writes normals_enable; it is sampled on the
// third corner of each triangle.
// The first two corners are only captured. From the third corner to the
// result beat the work runs as follows: the product pairs on two shared
// multipliers, then per vector a load, up to 5 normalizing steps and a
// check, the squares, the bit-serial square root, a setup, the three
// bit-serial dividers and a store, or, for a degenerate vector, a store of
// its flag, then the load into the output register.
// in_stall stays high while a triangle is in work. The result sits in an
// output register; the block goes on taking the next triangle's corners while
// the receiver stalls, and holds a finished result until that register is free.
// After reset the corner count is zero, normals are enabled and no beat is
// pending.
module triangle_tangent_normal import ttn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ttn_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ttn_out_t out_data,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data
);

  ttn_cmd_t    cmd;
  ttn_status_t status;

  // Sequencer.
  ttn_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .status      (status),
    .cmd         (cmd)
  );

  // Arithmetic.
  ttn_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule
